@@ sv/htfl_pkg.sv @@
`default_nettype none

package htfl_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int FRESH_W  = 9;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [FRESH_W-1:0] FRESH_LIMIT = FRESH_W'(CAPACITY);
    localparam logic [FRESH_W-1:0] FRESH_FIRST = FRESH_W'(1);

    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // write requests from the execute logic into the two memories
    typedef struct packed {
        logic               vals_we;
        logic [IDX_W-1:0]   vals_addr;
        logic [VALUE_W-1:0] vals_data;
        logic               link_we;
        logic [IDX_W-1:0]   link_addr;
        logic [IDX_W-1:0]   link_data;
    } htfl_wr_t;

endpackage

`default_nettype wire

@@ sv/htfl_mem.sv @@
`default_nettype none

module htfl_mem
    import htfl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rd_en,
    input  wire logic [IDX_W-1:0]   rd_value_addr,
    input  wire logic [IDX_W-1:0]   rd_link_addr,
    input  wire htfl_wr_t           wr,
    output logic      [VALUE_W-1:0] rd_value,
    output logic      [IDX_W-1:0]   rd_link
);

    logic [VALUE_W-1:0] value_mem [CAPACITY];
    logic [IDX_W-1:0]   link_mem  [CAPACITY];

    logic [VALUE_W-1:0] value_rd_reg;
    logic [IDX_W-1:0]   link_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.vals_we)
        begin
            value_mem[wr.vals_addr] <= wr.vals_data;
        end
        if (wr.link_we)
        begin
            link_mem[wr.link_addr] <= wr.link_data;
        end
    end

    // read for the incoming transaction, bypassing a write of the same edge
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.vals_we && (wr.vals_addr == rd_value_addr))
            begin
                value_rd_reg <= wr.vals_data;
            end
            else
            begin
                value_rd_reg <= value_mem[rd_value_addr];
            end
            if (wr.link_we && (wr.link_addr == rd_link_addr))
            begin
                link_rd_reg <= wr.link_data;
            end
            else
            begin
                link_rd_reg <= link_mem[rd_link_addr];
            end
        end
    end

    assign rd_value = value_rd_reg;
    assign rd_link  = link_rd_reg;

endmodule

`default_nettype wire

@@ sv/htfl_core.sv @@
`default_nettype none

module htfl_core
    import htfl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [IDX_W-1:0]    slot_index,
    input  wire logic [VALUE_W-1:0]  put_value,
    input  wire logic [VALUE_W-1:0]  rd_value,
    input  wire logic [IDX_W-1:0]    rd_link,
    output htfl_wr_t                 wr,
    output logic      [IDX_W-1:0]    head_next,
    output logic      [IDX_W-1:0]    handle,
    output logic      [VALUE_W-1:0]  read_value,
    output logic      [STATUS_W-1:0] status
);

    logic [CAPACITY-1:0] occupied_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [FRESH_W-1:0]  fresh_reg;
    logic [FRESH_W-1:0]  fresh_next;

    logic               set_occ;
    logic               clr_occ;
    logic [IDX_W-1:0]   put_slot;
    logic               found;

    assign found = occupied_reg[slot_index] && (rd_value != '0);

    always_comb
    begin
        wr         = '0;
        head_next  = head_reg;
        fresh_next = fresh_reg;
        set_occ    = 1'b0;
        clr_occ    = 1'b0;
        put_slot   = '0;
        handle     = '0;
        read_value = '0;
        status     = ST_NOT_FOUND;
        case (cmd) inside
            CMD_PUT:
            begin
                // freed slots first, then never-used ones
                if (head_reg != '0)
                begin
                    put_slot  = head_reg;
                    head_next = rd_link;
                end
                else if (fresh_reg < FRESH_LIMIT)
                begin
                    put_slot   = fresh_reg[IDX_W-1:0];
                    fresh_next = fresh_reg + FRESH_W'(1);
                end
                if (put_slot != '0)
                begin
                    set_occ      = 1'b1;
                    wr.vals_we   = 1'b1;
                    wr.vals_addr = put_slot;
                    wr.vals_data = put_value;
                    handle       = put_slot;
                    status       = ST_OK;
                end
                else
                begin
                    status = ST_FULL;
                end
            end
            CMD_GET, CMD_REMOVE:
            begin
                if (found)
                begin
                    read_value = rd_value;
                    status     = ST_OK;
                    if (cmd == CMD_REMOVE)
                    begin
                        clr_occ      = 1'b1;
                        wr.link_we   = 1'b1;
                        wr.link_addr = slot_index;
                        wr.link_data = head_reg;
                        head_next    = slot_index;
                    end
                end
            end
            default:
            begin
                status = ST_NOT_FOUND;
            end
        endcase
        if (!fire)
        begin
            wr         = '0;
            head_next  = head_reg;
            fresh_next = fresh_reg;
            set_occ    = 1'b0;
            clr_occ    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= '0;
            head_reg     <= '0;
            fresh_reg    <= FRESH_FIRST;
        end
        else
        begin
            head_reg  <= head_next;
            fresh_reg <= fresh_next;
            if (set_occ)
            begin
                occupied_reg[put_slot] <= 1'b1;
            end
            if (clr_occ)
            begin
                occupied_reg[slot_index] <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/handle_table_free_list_top.sv @@
`default_nettype none

// Handle table with a free list. Put stores a value and returns a handle,
// taken first from a stack of removed slots and otherwise from a counter
// rising from 1; get and remove return the stored value of an occupied
// slot that holds a nonzero value, and remove pushes the slot back. One
// transaction is taken every cycle unless the output stalls; a result
// passes the input register, where the value and free-link memories are
// read, then the result register, set from the single memory read of each
// item. Occupancy flags clear at reset; the memories need no clearing pass.
module handle_table_free_list_top
    import htfl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // slot_index[7:0], put_value[39:8]
    input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,  // handle[7:0], read_value[39:8]
    output logic      [1:0]  m_axis_tuser   // status[1:0]
);

    logic                a_valid_reg;
    logic [CMD_W-1:0]    a_cmd_reg;
    logic [IDX_W-1:0]    a_idx_reg;
    logic [VALUE_W-1:0]  a_pval_reg;

    logic                m_valid_reg;
    logic [IDX_W-1:0]    m_handle_reg;
    logic [VALUE_W-1:0]  m_value_reg;
    logic [STATUS_W-1:0] m_status_reg;

    logic                a_move;
    logic                accept;
    htfl_wr_t            wr;
    logic [IDX_W-1:0]    head_next;
    logic [VALUE_W-1:0]  rd_value;
    logic [IDX_W-1:0]    rd_link;
    logic [IDX_W-1:0]    handle;
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;

    assign a_move        = a_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !a_valid_reg || a_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    htfl_mem u_mem (
        .clk           (clk),
        .rd_en         (accept),
        .rd_value_addr (s_axis_tdata[IDX_W-1:0]),
        .rd_link_addr  (head_next),
        .wr            (wr),
        .rd_value      (rd_value),
        .rd_link       (rd_link)
    );

    htfl_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (a_move),
        .cmd        (a_cmd_reg),
        .slot_index (a_idx_reg),
        .put_value  (a_pval_reg),
        .rd_value   (rd_value),
        .rd_link    (rd_link),
        .wr         (wr),
        .head_next  (head_next),
        .handle     (handle),
        .read_value (read_value),
        .status     (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_move)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_cmd_reg  <= s_axis_tuser;
            a_idx_reg  <= s_axis_tdata[IDX_W-1:0];
            a_pval_reg <= s_axis_tdata[IDX_W+VALUE_W-1:IDX_W];
        end
        if (a_move)
        begin
            m_handle_reg <= handle;
            m_value_reg  <= read_value;
            m_status_reg <= status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_value_reg, m_handle_reg};
    assign m_axis_tuser  = m_status_reg;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import htfl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_TARGET  = 1850;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 17;
    localparam int QUIET_FIRST  = 1000;
    localparam int QUIET_LAST   = 1700;
    localparam int TAIL_CYCLES  = 8;

    typedef struct packed {
        bit                 wait_drain;
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] val;
    } table_op_t;

    typedef struct packed {
        logic [IDX_W-1:0]    handle;
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
    } table_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // slot_index[7:0], put_value[39:8]
    logic [1:0]  s_axis_tuser = '0;   // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // handle[7:0], read_value[39:8]
    logic [1:0]  m_axis_tuser;        // status[1:0]

    handle_table_free_list_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    table_op_t    pending_ops[$];
    table_reply_t expected_replies[$];
    table_op_t    next_op;

    int cycle_count = 0;
    int mismatch_count = 0;
    int ok_puts = 0;
    int full_puts = 0;
    int hits = 0;
    int misses = 0;
    int removes_ok = 0;

    // predicted table contents
    logic [VALUE_W-1:0] tbl_value [CAPACITY];
    bit                 tbl_occupied [CAPACITY];
    logic [IDX_W-1:0]   tbl_link [CAPACITY];
    logic [IDX_W-1:0]   tbl_free_top = '0;
    logic [FRESH_W-1:0] tbl_fresh = FRESH_FIRST;

    // light tracking of live handles while building the stimulus
    int live_handles[$];
    int freed_stack[$];
    int gen_fresh = 1;

    function void table_apply(input table_op_t op);
        table_reply_t r;
        logic [IDX_W-1:0] h;
        r.handle     = '0;
        r.read_value = '0;
        r.status     = ST_NOT_FOUND;
        h = '0;
        case (op.cmd) inside
            CMD_PUT:
            begin
                if (tbl_free_top != 0)
                begin
                    h = tbl_free_top;
                    tbl_free_top = tbl_link[h];
                end
                else if (tbl_fresh < FRESH_LIMIT)
                begin
                    h = tbl_fresh[IDX_W-1:0];
                    tbl_fresh = tbl_fresh + 1'b1;
                end
                if (h != 0)
                begin
                    tbl_value[h] = op.val;
                    tbl_occupied[h] = 1'b1;
                    r.handle = h;
                    r.status = ST_OK;
                    ok_puts++;
                end
                else
                begin
                    r.status = ST_FULL;
                    full_puts++;
                end
            end
            CMD_GET, CMD_REMOVE:
            begin
                if (tbl_occupied[op.idx] && tbl_value[op.idx] != 0)
                begin
                    r.read_value = tbl_value[op.idx];
                    r.status = ST_OK;
                    hits++;
                    if (op.cmd == CMD_REMOVE)
                    begin
                        tbl_occupied[op.idx] = 1'b0;
                        tbl_link[op.idx] = tbl_free_top;
                        tbl_free_top = op.idx;
                        removes_ok++;
                    end
                end
                else
                    misses++;
            end
            default:
                misses++;
        endcase
        expected_replies.push_back(r);
    endfunction

    function void queue_op(input logic [CMD_W-1:0] cmd, input int idx,
                           input logic [VALUE_W-1:0] val, input bit drain);
        table_op_t op;
        int h;
        op.wait_drain = drain;
        op.cmd = cmd;
        op.idx = idx[IDX_W-1:0];
        op.val = val;
        pending_ops.push_back(op);
        if (cmd == CMD_PUT)
        begin
            h = 0;
            if (freed_stack.size() > 0)
                h = freed_stack.pop_back();
            else if (gen_fresh < CAPACITY)
                h = gen_fresh++;
            // a slot holding zero stays occupied for good
            if (h != 0 && val != 0)
                live_handles.push_back(h);
        end
        else if (cmd == CMD_REMOVE)
        begin
            for (int i = 0; i < live_handles.size(); i++)
            begin
                if (live_handles[i] == idx)
                begin
                    live_handles.delete(i);
                    freed_stack.push_back(idx);
                    break;
                end
            end
        end
    endfunction

    function logic [VALUE_W-1:0] random_value();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return '0;
        else if (r < 6)
            return '1;
        else
            return $urandom;
    endfunction

    // slot index for get and remove: mostly a live handle, else any slot up to the highest handle handed out
    function int random_index();
        if (live_handles.size() > 0 && $urandom_range(99) < 80)
            return live_handles[$urandom_range(live_handles.size() - 1)];
        else
            return $urandom_range(gen_fresh - 1);
    endfunction

    function void random_op(input int put_pct, input int get_pct, input bit drain);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            queue_op(CMD_UNUSED, $urandom_range(gen_fresh - 1), $urandom, drain);
        else if (r < 3 + put_pct)
            queue_op(CMD_PUT, $urandom_range(255), random_value(), drain);
        else if (r < 3 + put_pct + get_pct)
            queue_op(CMD_GET, random_index(), $urandom, drain);
        else
            queue_op(CMD_REMOVE, random_index(), $urandom, drain);
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                next_op.wait_drain = 1'b0;
                next_op.cmd = s_axis_tuser;
                next_op.idx = s_axis_tdata[7:0];
                next_op.val = s_axis_tdata[39:8];
                table_apply(next_op);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_ops.size() > 0
                    && !(pending_ops[0].wait_drain && expected_replies.size() != 0)
                    && ((cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST)
                        || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_op = pending_ops.pop_front();
                    s_axis_tdata <= {next_op.val, next_op.idx};
                    s_axis_tuser <= next_op.cmd;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected result: handle %0d, read_value %0h, status %0d",
                           m_axis_tdata[7:0], m_axis_tdata[39:8], m_axis_tuser);
                    mismatch_count++;
                end
                else
                begin
                    table_reply_t want;
                    want = expected_replies.pop_front();
                    if (m_axis_tdata[7:0] !== want.handle)
                    begin
                        $error("handle: expected %0d, actual %0d",
                               want.handle, m_axis_tdata[7:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[39:8] !== want.read_value)
                    begin
                        $error("read_value: expected %0h, actual %0h",
                               want.read_value, m_axis_tdata[39:8]);
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end
            m_axis_tready <= (cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST)
                             || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_replies.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < CAPACITY; i++)
            tbl_occupied[i] = 1'b0;

        // directed: free slot 0, unused command, extremes, stored zero, lifo reuse
        queue_op(CMD_GET, 0, '1, 1'b0);
        queue_op(CMD_REMOVE, 0, '1, 1'b0);
        queue_op(CMD_UNUSED, 0, '1, 1'b0);
        queue_op(CMD_PUT, 255, 32'hFFFF_FFFF, 1'b0);
        queue_op(CMD_PUT, 0, 32'h0000_0000, 1'b0);
        queue_op(CMD_PUT, 128, 32'h0000_0001, 1'b0);
        queue_op(CMD_GET, 1, '0, 1'b0);
        queue_op(CMD_GET, 2, '0, 1'b0);
        queue_op(CMD_REMOVE, 2, '0, 1'b0);
        queue_op(CMD_GET, 2, '0, 1'b0);
        queue_op(CMD_GET, 3, '0, 1'b0);
        queue_op(CMD_REMOVE, 3, '0, 1'b0);
        queue_op(CMD_REMOVE, 1, '0, 1'b0);
        queue_op(CMD_GET, 3, '0, 1'b0);
        queue_op(CMD_REMOVE, 3, '0, 1'b0);
        queue_op(CMD_PUT, 127, 32'hA5A5_A5A5, 1'b0);
        queue_op(CMD_PUT, 0, 32'h5A5A_5A5A, 1'b0);
        queue_op(CMD_PUT, 255, 32'h1234_5678, 1'b0);
        queue_op(CMD_GET, 4, '0, 1'b0);
        queue_op(CMD_UNUSED, 4, 32'h8000_0000, 1'b0);

        // balanced mix, first item waits for the directed results to drain
        random_op(45, 25, 1'b1);
        repeat (500)
            random_op(45, 25, 1'b0);
        // fill the table up, then push some puts against a full table
        while (freed_stack.size() > 0 || gen_fresh < CAPACITY)
            random_op(88, 6, 1'b0);
        repeat (20)
            random_op(60, 30, 1'b0);
        // drain most of it again
        random_op(20, 30, 1'b1);
        repeat (400)
            random_op(20, 30, 1'b0);
        while (pending_ops.size() < ITEM_TARGET)
            random_op(40, 28, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_axis_tvalid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("puts stored %0d, puts refused as full %0d", ok_puts, full_puts);
        $display("lookups found %0d (removes %0d), not found %0d", hits, removes_ok, misses);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
sv/htfl_pkg.sv
sv/htfl_mem.sv
sv/htfl_core.sv
sv/handle_table_free_list_top.sv
tb/tb.sv
